@@ hdl/board_symmetry_canonicalizer_defines.svh @@
// Assertion helpers for the canonicaliser RTL.
`ifndef BOARD_SYMMETRY_CANONICALIZER_DEFINES_SVH
`define BOARD_SYMMETRY_CANONICALIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("board_symmetry_canonicalizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("board_symmetry_canonicalizer: next-cycle check failed");

`endif

@@ hdl/bsc_pkg.sv @@
package bsc_pkg;

    // Board geometry
    localparam int BOARD_SIDE = 8;
    localparam int CELL_BITS  = 64;
    localparam int CELL_IDX_W = $clog2(CELL_BITS);
    localparam int VARIANTS   = 8;
    localparam int SIDE_CELLS = BOARD_SIDE * BOARD_SIDE;
    localparam int USED_CELLS = (SIDE_CELLS < CELL_BITS) ? SIDE_CELLS : CELL_BITS;

    // Score and per-row partial sum widths (black and white both count)
    localparam int SCORE_W   = $clog2(USED_CELLS * (USED_CELLS - 1) + 1);
    localparam int ROW_CNT_W = $clog2(2 * BOARD_SIDE + 1);
    localparam int ROW_POS_W = $clog2(BOARD_SIDE * (BOARD_SIDE - 1) + 1);

    typedef logic [CELL_BITS-1:0] t_board;

    typedef struct packed {
        t_board black;
        t_board white;
        t_board legal;
    } t_pos;

    typedef logic [SCORE_W-1:0]   t_score;
    typedef t_score [VARIANTS-1:0] t_score_set;

    typedef logic [ROW_CNT_W-1:0]       t_row_cnt;
    typedef t_row_cnt [BOARD_SIDE-1:0]  t_row_cnts;
    typedef t_row_cnts [VARIANTS-1:0]   t_row_cnt_set;
    typedef logic [ROW_POS_W-1:0]       t_row_pos;
    typedef t_row_pos [BOARD_SIDE-1:0]  t_row_poss;
    typedef t_row_poss [VARIANTS-1:0]   t_row_pos_set;

    // Dihedral variants in output order
    typedef enum logic [2:0] {
        V_IDENT,
        V_VFLIP,
        V_HFLIP,
        V_TRANS,
        V_ANTI,
        V_ROT90,
        V_ROT180,
        V_ROT270
    } t_variant;

    // Cells that exist on the board
    function automatic t_board f_board_mask();
        t_board res;
        res = '0;
        for (int i = 0; i < CELL_BITS; i++) begin
            res[i] = (i < SIDE_CELLS);
        end
        return res;
    endfunction

    // Output cell (r,c) takes the source cell named by the variant
    function automatic t_board f_apply(input t_variant v, input t_board b);
        t_board res;
        int     m;
        int     sr;
        int     sc;
        int     s;
        int     d;
        res = '0;
        m   = BOARD_SIDE - 1;
        for (int r = 0; r < BOARD_SIDE; r++) begin
            for (int c = 0; c < BOARD_SIDE; c++) begin
                unique case (v)
                    V_IDENT:  begin sr = r;     sc = c;     end
                    V_VFLIP:  begin sr = m - r; sc = c;     end
                    V_HFLIP:  begin sr = r;     sc = m - c; end
                    V_TRANS:  begin sr = c;     sc = r;     end
                    V_ANTI:   begin sr = m - c; sc = m - r; end
                    V_ROT90:  begin sr = c;     sc = m - r; end
                    V_ROT180: begin sr = m - r; sc = m - c; end
                    V_ROT270: begin sr = m - c; sc = r;     end
                endcase
                d = r * BOARD_SIDE + c;
                s = sr * BOARD_SIDE + sc;
                if (d < CELL_BITS && s < CELL_BITS) begin
                    res[d[CELL_IDX_W-1:0]] = b[s[CELL_IDX_W-1:0]];
                end
            end
        end
        return res;
    endfunction

    // Rotations by a quarter turn undo each other; the rest are involutions
    function automatic t_variant f_inverse(input t_variant v);
        t_variant res;
        unique case (v)
            V_ROT90:  res = V_ROT270;
            V_ROT270: res = V_ROT90;
            default:  res = v;
        endcase
        return res;
    endfunction

endpackage

@@ hdl/bsc_score.sv @@
module bsc_score (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bsc_pkg::t_pos       i_pos,
    output logic                o_valid,
    output bsc_pkg::t_pos       o_pos,
    output bsc_pkg::t_score_set o_score
);
    import bsc_pkg::*;

    logic         r_v1;
    t_pos         r_pos1;
    t_row_cnt_set r_cnt1;
    t_row_pos_set r_rpos1;
    t_row_cnt_set n_cnt1;
    t_row_pos_set n_rpos1;

    logic         r_v2;
    t_pos         r_pos2;
    t_score_set   r_score2;
    t_score_set   n_score2;

    // Stage 1: per variant and output row, stone count and column sum
    always_comb begin
        t_board tb;
        t_board tw;
        int     d;
        for (int v = 0; v < VARIANTS; v++) begin
            tb = f_apply(t_variant'(3'(v)), i_pos.black);
            tw = f_apply(t_variant'(3'(v)), i_pos.white);
            for (int r = 0; r < BOARD_SIDE; r++) begin
                n_cnt1[v][r]  = '0;
                n_rpos1[v][r] = '0;
                for (int c = 0; c < BOARD_SIDE; c++) begin
                    d = r * BOARD_SIDE + c;
                    if (d < CELL_BITS) begin
                        n_cnt1[v][r] = n_cnt1[v][r]
                                     + ROW_CNT_W'(tb[d[CELL_IDX_W-1:0]])
                                     + ROW_CNT_W'(tw[d[CELL_IDX_W-1:0]]);
                        if (tb[d[CELL_IDX_W-1:0]]) begin
                            n_rpos1[v][r] = n_rpos1[v][r] + ROW_POS_W'(c);
                        end
                        if (tw[d[CELL_IDX_W-1:0]]) begin
                            n_rpos1[v][r] = n_rpos1[v][r] + ROW_POS_W'(c);
                        end
                    end
                end
            end
        end
    end

    // Stage 2: score = sum over rows of row_base * count + column sum
    always_comb begin
        for (int v = 0; v < VARIANTS; v++) begin
            n_score2[v] = '0;
            for (int r = 0; r < BOARD_SIDE; r++) begin
                n_score2[v] = n_score2[v]
                            + SCORE_W'(r * BOARD_SIDE) * SCORE_W'(r_cnt1[v][r])
                            + SCORE_W'(r_rpos1[v][r]);
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos1   <= i_pos;
            r_cnt1   <= n_cnt1;
            r_rpos1  <= n_rpos1;
            r_pos2   <= r_pos1;
            r_score2 <= n_score2;
        end
    end

    assign o_valid = r_v2;
    assign o_pos   = r_pos2;
    assign o_score = r_score2;

endmodule

@@ hdl/bsc_select.sv @@
module bsc_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  bsc_pkg::t_pos       i_pos,
    input  bsc_pkg::t_score_set i_score,
    output logic                o_valid,
    output bsc_pkg::t_pos       o_pos,
    output bsc_pkg::t_variant   o_orient,
    output bsc_pkg::t_variant   o_inverse
);
    import bsc_pkg::*;

    `include "board_symmetry_canonicalizer_defines.svh"

    logic     r_valid;
    t_pos     r_pos;
    t_variant r_orient;
    t_variant r_inverse;
    t_variant n_best;
    t_pos     n_pos;

    // Highest score wins, lowest variant on a tie
    always_comb begin
        t_score best_score;
        n_best     = V_IDENT;
        best_score = i_score[0];
        for (int v = 1; v < VARIANTS; v++) begin
            if (i_score[v] > best_score) begin
                best_score = i_score[v];
                n_best     = t_variant'(3'(v));
            end
        end
        n_pos.black = f_apply(n_best, i_pos.black);
        n_pos.white = f_apply(n_best, i_pos.white);
        n_pos.legal = f_apply(n_best, i_pos.legal);
    end

    // Output register: valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos     <= n_pos;
            r_orient  <= n_best;
            r_inverse <= f_inverse(n_best);
        end
    end

    assign o_valid   = r_valid;
    assign o_pos     = r_pos;
    assign o_orient  = r_orient;
    assign o_inverse = r_inverse;

    `BSC_ASSERT_IMPL(a_inverse_pair, i_clk, i_rst_n, r_valid, (r_inverse == r_orient && r_orient != V_ROT90 && r_orient != V_ROT270) || (r_orient == V_ROT90 && r_inverse == V_ROT270) || (r_orient == V_ROT270 && r_inverse == V_ROT90))
    `BSC_ASSERT_IMPL(a_off_board_zero, i_clk, i_rst_n, r_valid, ((r_pos.black | r_pos.white | r_pos.legal) & ~f_board_mask()) == '0)
    `BSC_ASSERT_NEXT(a_item_advances, i_clk, i_rst_n, i_en && i_valid, r_valid)
    `BSC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !i_en, $stable(r_valid) && $stable(r_orient) && $stable(r_pos))

endmodule

@@ hdl/board_symmetry_canonicalizer.sv @@
// Canonicalises an 8x8 position (black, white and legal-move bitboards) to the
// dihedral variant with the highest occupancy index sum, lowest variant on a
// tie, and returns the transformed boards with the variant index and the index
// that undoes it. Fully pipelined: one item per clock while not stalled, with
// stages for row sums, score add tree and pick-and-transform with output
// register. The whole pipeline advances whenever the output register is empty
// or being taken; i_out_ready low under a valid output holds every stage.
module board_symmetry_canonicalizer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bsc_pkg::t_board i_black_stones,
    input  bsc_pkg::t_board i_white_stones,
    input  bsc_pkg::t_board i_legal_mask,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bsc_pkg::t_board o_canon_black,
    output bsc_pkg::t_board o_canon_white,
    output bsc_pkg::t_board o_canon_legal,
    output logic [2:0]      o_orientation_index,
    output logic [2:0]      o_inverse_index
);
    import bsc_pkg::*;

    logic       w_en;
    t_pos       w_in_pos;
    logic       w_sc_valid;
    t_pos       w_sc_pos;
    t_score_set w_sc_score;
    t_pos       w_out_pos;
    t_variant   w_orient;
    t_variant   w_inverse;

    // Pipeline advance
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    assign w_in_pos.black = i_black_stones;
    assign w_in_pos.white = i_white_stones;
    assign w_in_pos.legal = i_legal_mask;

    bsc_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_pos   (w_in_pos),
        .o_valid (w_sc_valid),
        .o_pos   (w_sc_pos),
        .o_score (w_sc_score)
    );

    bsc_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_sc_valid),
        .i_pos     (w_sc_pos),
        .i_score   (w_sc_score),
        .o_valid   (o_out_valid),
        .o_pos     (w_out_pos),
        .o_orient  (w_orient),
        .o_inverse (w_inverse)
    );

    assign o_canon_black       = w_out_pos.black;
    assign o_canon_white       = w_out_pos.white;
    assign o_canon_legal       = w_out_pos.legal;
    assign o_orientation_index = w_orient;
    assign o_inverse_index     = w_inverse;

endmodule
